### sv/brb_pkg.sv
// Shared types, codes and sizes for the circular byte FIFO.
// Used by brb_ctrl, brb_datapath and byte_ring_buffer; depends on nothing.
`timescale 1ns / 1ps

package brb_pkg;

  // Field widths of the transaction ports.
  localparam int BRB_ACT_W  = 3;
  localparam int BRB_CNT_W  = 4;
  localparam int BRB_DATA_W = 64;
  localparam int BRB_STS_W  = 2;
  localparam int BRB_CAP_W  = 11;
  localparam int BRB_FILL_W = 11;

  // Byte lanes in one burst and the width of a lane index.
  localparam int BRB_LANES = 8;
  localparam int BRB_IDX_W = $clog2(BRB_LANES);

  // Default storage depth and the capacity after reset.
  localparam int BRB_DEPTH     = 1024;
  localparam int BRB_CAP_RESET = 1024;

  // Action codes.
  localparam logic [BRB_ACT_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [BRB_ACT_W-1:0] ACT_READ  = 3'd1;
  localparam logic [BRB_ACT_W-1:0] ACT_PEEK  = 3'd2;
  localparam logic [BRB_ACT_W-1:0] ACT_SKIP  = 3'd3;
  localparam logic [BRB_ACT_W-1:0] ACT_CLEAR = 3'd4;

  // Result status codes.
  localparam logic [BRB_STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [BRB_STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [BRB_STS_W-1:0] STS_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_we;  // write the capacity register and empty the buffer
    logic load;    // capture an accepted input transaction
    logic check;   // evaluate the request and set up the byte walk
    logic step;    // move one byte
    logic finish;  // commit the pointers and load the result register
  } brb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic xfer;  // the request is granted and moves at least one byte
    logic last;  // the current step moves the final byte
    logic rd;    // the request reads memory, so the drain state follows
  } brb_sts_t;

endpackage

### sv/brb_ctrl.sv
// Sequencing state machine of the circular byte FIFO.
// Drives the handshakes and the brb_datapath commands; uses brb_pkg.
`timescale 1ns / 1ps

module brb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  brb_pkg::brb_sts_t sts,
  output brb_pkg::brb_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_XFER   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  // Handshakes: one transaction at a time, configuration only when idle.
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    cmd.cfg_we = cfg_valid && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.xfer ? S_XFER : S_FINISH;
      end
      S_XFER: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = sts.rd ? S_DRAIN : S_FINISH;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The result register is full from a finish until its transaction is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted input transaction is evaluated in the following cycle.
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHECK))
    else $error("accepted transaction was not evaluated");

  // A finish never overwrites a result that is still waiting.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");
`endif

endmodule

### sv/brb_datapath.sv
// Datapath of the circular byte FIFO: byte memory, pointers, fill count,
// capacity register and result register. Uses brb_pkg; driven by brb_ctrl.
`timescale 1ns / 1ps

module brb_datapath #(
  parameter int DEPTH = brb_pkg::BRB_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  brb_pkg::brb_cmd_t               cmd,
  output brb_pkg::brb_sts_t               sts,
  input  logic [brb_pkg::BRB_CAP_W-1:0]   cfg_data,
  input  logic [brb_pkg::BRB_ACT_W-1:0]   in_action,
  input  logic [brb_pkg::BRB_CNT_W-1:0]   in_count,
  input  logic [brb_pkg::BRB_DATA_W-1:0]  in_write_data,
  output logic [brb_pkg::BRB_STS_W-1:0]   out_status,
  output logic [brb_pkg::BRB_DATA_W-1:0]  out_read_data,
  output logic [brb_pkg::BRB_FILL_W-1:0]  out_fill_level
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = AW + 1;
  localparam int EW      = (CW > brb_pkg::BRB_CAP_W) ? CW : brb_pkg::BRB_CAP_W;
  localparam int CAP_RST = (brb_pkg::BRB_CAP_RESET > DEPTH) ? DEPTH : brb_pkg::BRB_CAP_RESET;
  localparam int NW      = brb_pkg::BRB_CNT_W;
  localparam int IW      = brb_pkg::BRB_IDX_W;

  // Byte memory with a registered read port.
  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;

  // Control state.
  logic [AW-1:0] rptr_r;
  logic [AW-1:0] wptr_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] cap_r;
  logic          pend_r;

  // Transaction and walk registers.
  logic [brb_pkg::BRB_ACT_W-1:0]  act_r;
  logic [NW-1:0]                  n_r;
  logic [brb_pkg::BRB_DATA_W-1:0] wdata_r;
  logic [brb_pkg::BRB_DATA_W-1:0] rdata_r;
  logic [brb_pkg::BRB_STS_W-1:0]  status_r;
  logic [AW-1:0]                  addr_r;
  logic [IW-1:0]                  idx_r;
  logic [IW-1:0]                  slot_r;

  // Result register.
  logic [brb_pkg::BRB_STS_W-1:0]  res_status_r;
  logic [brb_pkg::BRB_DATA_W-1:0] res_data_r;
  logic [brb_pkg::BRB_FILL_W-1:0] res_fill_r;

  logic [NW-1:0]                  n_sat;
  logic [EW-1:0]                  cfg_ext;
  logic [CW-1:0]                  cap_cfg;
  logic [CW:0]                    wr_sum;
  logic [brb_pkg::BRB_STS_W-1:0]  status_c;
  logic                           moves_c;
  logic                           is_rd;
  logic [CW-1:0]                  addr_p1;
  logic [AW-1:0]                  addr_inc;

  // Byte count saturates to the lane count.
  assign n_sat = (in_count > NW'(brb_pkg::BRB_LANES)) ? NW'(brb_pkg::BRB_LANES) : in_count;

  // Capacity written out of range is clamped to 1..DEPTH.
  assign cfg_ext = EW'(cfg_data);
  always_comb begin
    if (cfg_ext == '0) begin
      cap_cfg = CW'(1);
    end else if (cfg_ext > EW'(DEPTH)) begin
      cap_cfg = CW'(DEPTH);
    end else begin
      cap_cfg = CW'(cfg_ext);
    end
  end

  // Admission check for the captured transaction.
  assign wr_sum = {1'b0, cnt_r} + (CW + 1)'(n_r);
  assign is_rd  = (act_r == brb_pkg::ACT_READ) || (act_r == brb_pkg::ACT_PEEK);
  always_comb begin
    status_c = brb_pkg::STS_OK;
    moves_c  = 1'b0;
    case (act_r) inside
      brb_pkg::ACT_WRITE: begin
        if (wr_sum > {1'b0, cap_r}) begin
          status_c = brb_pkg::STS_FULL;
        end else begin
          moves_c = (n_r != '0);
        end
      end
      brb_pkg::ACT_READ, brb_pkg::ACT_PEEK, brb_pkg::ACT_SKIP: begin
        if (cnt_r < CW'(n_r)) begin
          status_c = brb_pkg::STS_EMPTY;
        end else begin
          moves_c = (n_r != '0);
        end
      end
      default: begin
        status_c = brb_pkg::STS_OK;
      end
    endcase
  end

  assign sts.xfer = moves_c;
  assign sts.last = ({1'b0, idx_r} + NW'(1)) == n_r;
  assign sts.rd   = is_rd;

  // Walk address advances by one and wraps at the capacity.
  assign addr_p1  = {1'b0, addr_r} + CW'(1);
  assign addr_inc = (addr_p1 == cap_r) ? '0 : addr_p1[AW-1:0];

  // Fill count after the transaction commits.
  always_comb begin
    cnt_nxt = cnt_r;
    if (status_r == brb_pkg::STS_OK) begin
      case (act_r) inside
        brb_pkg::ACT_WRITE: cnt_nxt = cnt_r + CW'(n_r);
        brb_pkg::ACT_READ, brb_pkg::ACT_SKIP: cnt_nxt = cnt_r - CW'(n_r);
        brb_pkg::ACT_CLEAR: cnt_nxt = '0;
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  // Memory write and registered read, one byte per cycle.
  always_ff @(posedge clk) begin
    if (cmd.step && (act_r == brb_pkg::ACT_WRITE)) begin
      mem[addr_r] <= wdata_r[{idx_r, 3'b000} +: 8];
    end
    mem_q <= mem[addr_r];
  end

  // Pointers, fill count, capacity and the pending read flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r <= '0;
      wptr_r <= '0;
      cnt_r  <= '0;
      cap_r  <= CW'(CAP_RST);
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.step && is_rd;
      if (cmd.cfg_we) begin
        cap_r  <= cap_cfg;
        rptr_r <= '0;
        wptr_r <= '0;
        cnt_r  <= '0;
      end else if (cmd.finish) begin
        cnt_r <= cnt_nxt;
        if (status_r == brb_pkg::STS_OK) begin
          case (act_r) inside
            brb_pkg::ACT_WRITE: wptr_r <= addr_r;
            brb_pkg::ACT_READ, brb_pkg::ACT_SKIP: rptr_r <= addr_r;
            brb_pkg::ACT_CLEAR: begin
              rptr_r <= '0;
              wptr_r <= '0;
            end
            default: rptr_r <= rptr_r;
          endcase
        end
      end
    end
  end

  // Transaction capture, byte walk and read data assembly.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      n_r     <= n_sat;
      wdata_r <= in_write_data;
    end
    if (cmd.check) begin
      status_r <= status_c;
      addr_r   <= (act_r == brb_pkg::ACT_WRITE) ? wptr_r : rptr_r;
      idx_r    <= '0;
      rdata_r  <= '0;
    end
    if (cmd.step) begin
      addr_r <= addr_inc;
      idx_r  <= idx_r + IW'(1);
      slot_r <= idx_r;
    end
    if (pend_r) begin
      rdata_r[{slot_r, 3'b000} +: 8] <= mem_q;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status_r <= status_r;
      res_data_r   <= rdata_r;
      res_fill_r   <= brb_pkg::BRB_FILL_W'(cnt_nxt);
    end
  end

  assign out_status     = res_status_r;
  assign out_read_data  = res_data_r;
  assign out_fill_level = res_fill_r;

`ifndef NO_ASSERTIONS
  // The fill count never exceeds the capacity.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cap_r)
    else $error("fill count above capacity");

  // Both pointers stay below the capacity.
  a_ptr_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rptr_r} < cap_r) && ({1'b0, wptr_r} < cap_r))
    else $error("pointer at or above capacity");

  // Read data lands only for reading actions.
  a_pend_rd: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ((act_r == brb_pkg::ACT_READ) || (act_r == brb_pkg::ACT_PEEK)))
    else $error("memory read for a non-reading action");
`endif

endmodule

### sv/byte_ring_buffer.sv
// Top level of the circular byte FIFO with a configurable capacity.
// Instantiates brb_ctrl and brb_datapath; uses brb_pkg.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_action, in_count, in_write_data
//   out_     output     out_valid/out_stall out_status, out_read_data, out_fill_level
//   cfg_     input      cfg_valid/cfg_ready cfg_capacity
//
// With no byte to move, an accepted transaction passes the check and finish states;
// a write or skip also walks its bytes in the transfer state, and a read or peek
// adds the drain state after the walk, as the single byte-wide memory port moves one
// byte per cycle. The next input is accepted in the cycle after the result is loaded.
// Reset is synchronous and empties the buffer with capacity 1024 (at most DEPTH).
// A stalled result holds the next transaction in its last cycle; the next input
// is accepted while a result waits.
`timescale 1ns / 1ps

module byte_ring_buffer #(
  parameter int DEPTH = brb_pkg::BRB_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [brb_pkg::BRB_ACT_W-1:0]   in_action,
  input  logic [brb_pkg::BRB_CNT_W-1:0]   in_count,
  input  logic [brb_pkg::BRB_DATA_W-1:0]  in_write_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [brb_pkg::BRB_STS_W-1:0]   out_status,
  output logic [brb_pkg::BRB_DATA_W-1:0]  out_read_data,
  output logic [brb_pkg::BRB_FILL_W-1:0]  out_fill_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brb_pkg::BRB_CAP_W-1:0]   cfg_capacity
);

  brb_pkg::brb_cmd_t cmd;
  brb_pkg::brb_sts_t sts;

  // Sequencer.
  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage, pointers and result register.
  brb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_data       (cfg_capacity),
    .in_action      (in_action),
    .in_count       (in_count),
    .in_write_data  (in_write_data),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .out_fill_level (out_fill_level)
  );

endmodule

### tb/tb_byte_ring_buffer.sv
// Self-checking testbench for the byte_ring_buffer circular byte FIFO.
// Depends on brb_pkg and byte_ring_buffer. A local predictor mirrors the FIFO
// state, and a checker compares every result transaction with the prediction.
`timescale 1ns / 1ps

module tb_byte_ring_buffer;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int MAX_IDLE       = 18;
  localparam int DRAIN_PAUSE    = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MODE_SPAN      = 64;

  // Action codes above clear are unused and must leave the buffer alone.
  localparam logic [brb_pkg::BRB_ACT_W-1:0] ACT_FIRST_UNUSED = brb_pkg::ACT_CLEAR + 3'd1;
  localparam logic [brb_pkg::BRB_ACT_W-1:0] ACT_LAST_UNUSED  = '1;

  typedef struct {
    logic [brb_pkg::BRB_STS_W-1:0]  status;
    logic [brb_pkg::BRB_DATA_W-1:0] data;
    logic [brb_pkg::BRB_FILL_W-1:0] fill;
  } fifo_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [brb_pkg::BRB_ACT_W-1:0]  in_action;
  logic [brb_pkg::BRB_CNT_W-1:0]  in_count;
  logic [brb_pkg::BRB_DATA_W-1:0] in_write_data;
  logic                           out_valid;
  logic                           out_stall;
  logic [brb_pkg::BRB_STS_W-1:0]  out_status;
  logic [brb_pkg::BRB_DATA_W-1:0] out_read_data;
  logic [brb_pkg::BRB_FILL_W-1:0] out_fill_level;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [brb_pkg::BRB_CAP_W-1:0]  cfg_capacity;

  // Predictor state: byte store, pointers, fill level and capacity register.
  logic [7:0]                    model_mem [brb_pkg::BRB_DEPTH];
  int                            model_rd_ptr;
  int                            model_wr_ptr;
  int                            model_level;
  logic [brb_pkg::BRB_CAP_W-1:0] model_capacity;

  fifo_result_t pending_results[$];
  int           error_count;
  int           sent_count;
  int           quiet_cycles;
  bit           tx_no_gaps;
  bit           rx_no_stalls;

  byte_ring_buffer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_count       (in_count),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .out_fill_level (out_fill_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  // Free-running clock.
  always begin
    #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Apply one action to the mirrored FIFO and return the result it should give.
  function automatic fifo_result_t predict_fifo_action(
      logic [brb_pkg::BRB_ACT_W-1:0] act,
      logic [brb_pkg::BRB_CNT_W-1:0] cnt,
      logic [brb_pkg::BRB_DATA_W-1:0] wdata);
    fifo_result_t res;
    int           cap;
    int           n;
    int           i;
    cap = int'(model_capacity);
    if (cap == 0) cap = 1;
    if (cap > brb_pkg::BRB_DEPTH) cap = brb_pkg::BRB_DEPTH;
    n = (int'(cnt) > brb_pkg::BRB_LANES) ? brb_pkg::BRB_LANES : int'(cnt);
    res.status = brb_pkg::STS_OK;
    res.data   = '0;
    case (act) inside
      brb_pkg::ACT_WRITE: begin
        if (model_level + n > cap) begin
          res.status = brb_pkg::STS_FULL;
        end else begin
          for (i = 0; i < n; i++) begin
            model_mem[(model_wr_ptr + i) % cap] = wdata[8*i +: 8];
          end
          model_wr_ptr = (model_wr_ptr + n) % cap;
          model_level  = model_level + n;
        end
      end
      brb_pkg::ACT_READ, brb_pkg::ACT_PEEK, brb_pkg::ACT_SKIP: begin
        if (model_level < n) begin
          res.status = brb_pkg::STS_EMPTY;
        end else begin
          if (act != brb_pkg::ACT_SKIP) begin
            for (i = 0; i < n; i++) begin
              res.data[8*i +: 8] = model_mem[(model_rd_ptr + i) % cap];
            end
          end
          if (act != brb_pkg::ACT_PEEK) begin
            model_rd_ptr = (model_rd_ptr + n) % cap;
            model_level  = model_level - n;
          end
        end
      end
      brb_pkg::ACT_CLEAR: begin
        model_rd_ptr = 0;
        model_wr_ptr = 0;
        model_level  = 0;
      end
      default: begin
      end
    endcase
    res.fill = model_level[brb_pkg::BRB_FILL_W-1:0];
    return res;
  endfunction

  function automatic logic [brb_pkg::BRB_DATA_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Send one transaction after a random gap and record its expected result.
  task automatic send_request(logic [brb_pkg::BRB_ACT_W-1:0] act,
                              logic [brb_pkg::BRB_CNT_W-1:0] cnt,
                              logic [brb_pkg::BRB_DATA_W-1:0] wdata);
    int gap;
    if (sent_count % MODE_SPAN == 0) tx_no_gaps = ($urandom_range(0, 3) == 0);
    gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_count      <= cnt;
    in_write_data <= wdata;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pending_results.push_back(predict_fifo_action(act, cnt, wdata));
    sent_count++;
  endtask

  // Write the capacity register once the block has drained; this also empties it.
  task automatic program_capacity(logic [brb_pkg::BRB_CAP_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    model_capacity = value;
    model_rd_ptr   = 0;
    model_wr_ptr   = 0;
    model_level    = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Refused transfers on an empty buffer, zero counts and unused action codes.
  task automatic test_empty_and_unused();
    send_request(brb_pkg::ACT_READ, 4'd1, '0);
    send_request(brb_pkg::ACT_PEEK, 4'd2, '1);
    send_request(brb_pkg::ACT_SKIP, 4'd8, '0);
    send_request(brb_pkg::ACT_READ, 4'd0, '0);
    send_request(brb_pkg::ACT_WRITE, 4'd0, '1);
    send_request(ACT_FIRST_UNUSED, 4'd3, random_word());
    send_request(ACT_LAST_UNUSED, 4'd15, '1);
  endtask

  // Full-width bursts, saturated counts, peek, read and skip.
  task automatic test_full_bursts();
    send_request(brb_pkg::ACT_WRITE, 4'd8, '1);
    send_request(brb_pkg::ACT_WRITE, 4'd15, 64'h0807_0605_0403_0201);
    send_request(brb_pkg::ACT_PEEK, 4'd8, '0);
    send_request(brb_pkg::ACT_READ, 4'd15, '1);
    send_request(brb_pkg::ACT_SKIP, 4'd3, '0);
    send_request(brb_pkg::ACT_READ, 4'd5, '0);
  endtask

  // Clear on a filled buffer and on an empty one.
  task automatic test_clear();
    send_request(brb_pkg::ACT_WRITE, 4'd5, random_word());
    send_request(brb_pkg::ACT_CLEAR, 4'd0, '0);
    send_request(brb_pkg::ACT_READ, 4'd1, '0);
    send_request(brb_pkg::ACT_CLEAR, 4'd8, '1);
  endtask

  // Small capacity: refused writes at the limit and pointer wrap.
  task automatic test_small_capacity_wrap();
    program_capacity(11'd5);
    send_request(brb_pkg::ACT_WRITE, 4'd8, random_word());
    send_request(brb_pkg::ACT_WRITE, 4'd5, 64'h0000_00ee_ddcc_bbaa);
    send_request(brb_pkg::ACT_WRITE, 4'd1, random_word());
    send_request(brb_pkg::ACT_READ, 4'd3, '0);
    send_request(brb_pkg::ACT_WRITE, 4'd3, 64'h0000_0000_0033_2211);
    send_request(brb_pkg::ACT_PEEK, 4'd5, '0);
    send_request(brb_pkg::ACT_READ, 4'd5, '0);
  endtask

  // A capacity of zero behaves as a single byte.
  task automatic test_zero_capacity();
    program_capacity(11'd0);
    send_request(brb_pkg::ACT_WRITE, 4'd2, random_word());
    send_request(brb_pkg::ACT_WRITE, 4'd1, 64'h5a);
    send_request(brb_pkg::ACT_WRITE, 4'd1, 64'ha5);
    send_request(brb_pkg::ACT_READ, 4'd1, '0);
  endtask

  // Random traffic: a write-heavy stretch to reach full, then a drain-heavy one.
  task automatic test_random_traffic(logic [brb_pkg::BRB_CAP_W-1:0] cap, int n_items);
    int                            k;
    int                            pick;
    int                            write_pct;
    logic [brb_pkg::BRB_ACT_W-1:0] act;
    logic [brb_pkg::BRB_CNT_W-1:0] cnt;
    program_capacity(cap);
    for (k = 0; k < n_items; k++) begin
      write_pct = (k < (n_items * 3) / 5) ? 85 : 20;
      if ($urandom_range(0, 99) < write_pct) begin
        act = brb_pkg::ACT_WRITE;
        cnt = (write_pct > 50) ? brb_pkg::BRB_CNT_W'($urandom_range(4, 15)) :
                                 brb_pkg::BRB_CNT_W'($urandom_range(0, 8));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 2) act = brb_pkg::ACT_CLEAR;
        else if (pick < 4) act = brb_pkg::BRB_ACT_W'($urandom_range(ACT_FIRST_UNUSED,
                                                                     ACT_LAST_UNUSED));
        else if (pick < 49) act = brb_pkg::ACT_READ;
        else if (pick < 79) act = brb_pkg::ACT_PEEK;
        else act = brb_pkg::ACT_SKIP;
        cnt = ($urandom_range(0, 9) == 0) ? brb_pkg::BRB_CNT_W'($urandom_range(9, 15)) :
                                            brb_pkg::BRB_CNT_W'($urandom_range(0, 8));
      end
      send_request(act, cnt, random_word());
    end
  endtask

  // Result side: random stall before each result, with stall-free stretches.
  initial begin
    int hold;
    int served;
    out_stall    = 1'b0;
    served       = 0;
    rx_no_stalls = 1'b0;
    forever begin
      if (served % MODE_SPAN == 0) rx_no_stalls = ($urandom_range(0, 3) == 0);
      hold = rx_no_stalls ? 0 : $urandom_range(0, MAX_IDLE);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      served++;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    fifo_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d, data %h, fill %0d", $time,
                 out_status, out_read_data, out_fill_level);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   want.status, out_status);
          error_count++;
        end
        if (out_read_data !== want.data) begin
          $display("%0t: read_data mismatch, expected %h, actual %h", $time,
                   want.data, out_read_data);
          error_count++;
        end
        if (out_fill_level !== want.fill) begin
          $display("%0t: fill_level mismatch, expected %0d, actual %0d", $time,
                   want.fill, out_fill_level);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("byte_ring_buffer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed tests, random phases, drain and verdict.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = brb_pkg::ACT_WRITE;
    in_count       = '0;
    in_write_data  = '0;
    cfg_valid      = 1'b0;
    cfg_capacity   = '0;
    sent_count     = 0;
    tx_no_gaps     = 1'b0;
    model_capacity = brb_pkg::BRB_CAP_W'(brb_pkg::BRB_CAP_RESET);
    model_rd_ptr   = 0;
    model_wr_ptr   = 0;
    model_level    = 0;
    foreach (model_mem[j]) model_mem[j] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_and_unused();
    test_full_bursts();
    test_clear();
    test_small_capacity_wrap();
    test_zero_capacity();

    test_random_traffic(11'd2047, 400);
    test_random_traffic(11'd1024, 150);
    test_random_traffic(11'd1, 150);
    test_random_traffic(11'd0, 100);
    test_random_traffic(11'd9, 200);
    test_random_traffic(11'd1025, 150);
    test_random_traffic(brb_pkg::BRB_CAP_W'($urandom_range(2, 64)), 200);
    test_random_traffic(brb_pkg::BRB_CAP_W'($urandom_range(1, 2047)), 200);
    test_random_traffic(11'd8, 150);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (error_count == 0) begin
      $display("byte_ring_buffer test passed");
    end else begin
      $display("byte_ring_buffer test failed");
    end
    $finish;
  end

endmodule

### byte_ring_buffer.f
sv/brb_pkg.sv
sv/brb_ctrl.sv
sv/brb_datapath.sv
sv/byte_ring_buffer.sv
tb/tb_byte_ring_buffer.sv
